>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is asserted
`define BBA_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked property, also active during reset
`define BBA_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> src/bba_pkg.sv
// shared types and codes of the buddy block allocator
package bba_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_BOUNDS  = 3'd2;
    localparam logic [2:0] ST_LEVEL   = 3'd3;
    localparam logic [2:0] ST_ALIGN   = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_START,
        OP_RD_CUR,
        OP_RD_SIB,
        OP_RD_PAR,
        OP_DESCEND,
        OP_NEXT_SIB,
        OP_UP,
        OP_WR_FOUND,
        OP_CLAIM_WR,
        OP_F_CLR,
        OP_F_UPWR,
        OP_RESTORE,
        OP_F_SPLWR,
        OP_FIN_OK,
        OP_FIN_ERR,
        OP_FIN_NOSPACE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic is_free;
        logic err;
        logic at_root;
        logic cur_odd;
        logic at_target;
        logic rd_alloc;
        logic rd_split;
    } t_dp_stat;

endpackage

>>> src/bba_ctrl.sv
// sequencer for search, claim, free and clearing pass
module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  bba_pkg::t_dp_stat i_stat,
    output bba_pkg::t_cmd     o_cmd,
    output logic              busy,
    output logic              o_valid
);

    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_DECODE  = 16'h0004,
        S_A_RD    = 16'h0008,
        S_A_CHK   = 16'h0010,
        S_A_BT    = 16'h0020,
        S_C_RD    = 16'h0040,
        S_C_WR    = 16'h0080,
        S_F_RD    = 16'h0100,
        S_F_CLR   = 16'h0200,
        S_F_UP    = 16'h0400,
        S_F_UPCHK = 16'h0800,
        S_F_SIB   = 16'h1000,
        S_F_SCHK  = 16'h2000,
        S_F_PCHK  = 16'h4000,
        S_DONE    = 16'h8000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd.op = bba_pkg::OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = bba_pkg::OP_CLEAR;
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = bba_pkg::OP_LOAD;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.err) begin
                    o_cmd.op = bba_pkg::OP_FIN_ERR;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = bba_pkg::OP_START;
                    n_state  = i_stat.is_free ? S_F_RD : S_A_RD;
                end
            end
            S_A_RD: begin
                o_cmd.op = bba_pkg::OP_RD_CUR;
                n_state  = S_A_CHK;
            end
            S_A_CHK: begin
                if (i_stat.rd_alloc || (i_stat.at_target && i_stat.rd_split)) begin
                    n_state = S_A_BT;
                end else if (i_stat.at_target) begin
                    o_cmd.op = bba_pkg::OP_WR_FOUND;
                    n_state  = S_C_RD;
                end else begin
                    o_cmd.op = bba_pkg::OP_DESCEND;
                    n_state  = S_A_RD;
                end
            end
            S_A_BT: begin
                // climb while on a right child, then try the right sibling
                if (i_stat.at_root) begin
                    o_cmd.op = bba_pkg::OP_FIN_NOSPACE;
                    n_state  = S_DONE;
                end else if (i_stat.cur_odd) begin
                    o_cmd.op = bba_pkg::OP_NEXT_SIB;
                    n_state  = S_A_RD;
                end else begin
                    o_cmd.op = bba_pkg::OP_UP;
                end
            end
            S_C_RD: begin
                if (i_stat.at_root) begin
                    o_cmd.op = bba_pkg::OP_FIN_OK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = bba_pkg::OP_RD_SIB;
                    n_state  = S_C_WR;
                end
            end
            S_C_WR: begin
                o_cmd.op = bba_pkg::OP_CLAIM_WR;
                n_state  = S_C_RD;
            end
            S_F_RD: begin
                o_cmd.op = bba_pkg::OP_RD_CUR;
                n_state  = S_F_CLR;
            end
            S_F_CLR: begin
                o_cmd.op = bba_pkg::OP_F_CLR;
                n_state  = S_F_UP;
            end
            S_F_UP: begin
                if (i_stat.at_root) begin
                    o_cmd.op = bba_pkg::OP_RESTORE;
                    n_state  = S_F_SIB;
                end else begin
                    o_cmd.op = bba_pkg::OP_RD_PAR;
                    n_state  = S_F_UPCHK;
                end
            end
            S_F_UPCHK: begin
                if (i_stat.rd_alloc) begin
                    o_cmd.op = bba_pkg::OP_F_UPWR;
                    n_state  = S_F_UP;
                end else begin
                    o_cmd.op = bba_pkg::OP_RESTORE;
                    n_state  = S_F_SIB;
                end
            end
            S_F_SIB: begin
                if (i_stat.at_root) begin
                    o_cmd.op = bba_pkg::OP_FIN_OK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = bba_pkg::OP_RD_SIB;
                    n_state  = S_F_SCHK;
                end
            end
            S_F_SCHK: begin
                if (i_stat.rd_alloc || i_stat.rd_split) begin
                    o_cmd.op = bba_pkg::OP_FIN_OK;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = bba_pkg::OP_RD_PAR;
                    n_state  = S_F_PCHK;
                end
            end
            S_F_PCHK: begin
                o_cmd.op = bba_pkg::OP_F_SPLWR;
                n_state  = S_F_SIB;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

>>> src/bba_datapath.sv
// mark memory, node walker, request decode and result registers
module bba_datapath #(
    parameter int DEPTH = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bba_pkg::t_cmd      i_cmd,
    output bba_pkg::t_dp_stat  o_stat,
    input  logic               i_heap_base_we,
    input  logic [31:0]        i_heap_base_wdata,
    input  logic               i_action,
    input  logic [15:0]        i_slot_count,
    input  logic [31:0]        i_data_address,
    input  logic signed [31:0] i_header_level,
    output logic [2:0]         o_status,
    output logic [31:0]        o_result_address,
    output logic [3:0]         o_block_level
);

    localparam int SIZE  = 1 << DEPTH;
    localparam int NW    = DEPTH + 1;
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int NODES = 2 * SIZE - 1;
    localparam logic [NW-1:0] LAST_NODE = NW'(NODES - 1);

    // bit 1 allocated, bit 0 split
    logic [1:0] r_mem [0:(1 << NW) - 1];
    logic [1:0] r_rd;

    logic              r_act;
    logic [15:0]       r_cnt;
    logic [31:0]       r_daddr;
    logic signed [31:0] r_hlvl;
    logic [31:0]       r_base;
    logic [NW-1:0]     r_cur, r_node, r_found, r_clr;
    logic [LW-1:0]     r_lvl, r_tlvl;
    logic              r_claim;
    logic [2:0]        r_status;
    logic [31:0]       r_addr;
    logic [3:0]        r_blvl;

    function automatic logic [4:0] bit_len(input logic [15:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) n = 5'(i + 1);
        end
        return n;
    endfunction

    // request decode from the latched item
    logic [4:0]    bl;
    logic [31:0]   t32, header, rel, sh32, mask, fnode32;
    logic [LW-1:0] d_tlvl, hl;
    logic          too_big, bad_bounds, bad_lvl, unaligned;
    logic [2:0]    d_err;
    logic [NW-1:0] fnode;

    always_comb begin
        bl      = bit_len(r_cnt);
        too_big = 32'(bl) > 32'(DEPTH);
        t32     = 32'(DEPTH) - 32'(bl);
        d_tlvl  = t32[LW-1:0];
        header  = r_daddr - 32'd1;
        rel     = header - r_base;
        bad_bounds = rel >= 32'(SIZE);
        bad_lvl = r_hlvl[31] || (r_hlvl > 32'sd0 + 32'(DEPTH));
        hl      = r_hlvl[LW-1:0];
        sh32    = 32'(DEPTH) - 32'(hl);
        mask    = (32'd1 << sh32) - 32'd1;
        unaligned = (rel & mask) != 32'd0;
        fnode32 = ((32'd1 << hl) - 32'd1) + (rel >> sh32);
        fnode   = fnode32[NW-1:0];
        if (r_act == bba_pkg::ACT_ALLOC) begin
            d_err = too_big ? bba_pkg::ST_NOSPACE : bba_pkg::ST_OK;
        end else if (bad_bounds) begin
            d_err = bba_pkg::ST_BOUNDS;
        end else if (bad_lvl) begin
            d_err = bba_pkg::ST_LEVEL;
        end else if (unaligned) begin
            d_err = bba_pkg::ST_ALIGN;
        end else begin
            d_err = bba_pkg::ST_OK;
        end
    end

    // tree neighbors of the current node
    logic [NW-1:0] parent, sib;
    assign parent = (r_cur - NW'(1)) >> 1;
    assign sib    = r_cur[0] ? (r_cur + NW'(1)) : (r_cur - NW'(1));

    // result address of the claimed block
    logic [31:0] off32, fsh32, a_addr, tl32;
    always_comb begin
        off32  = 32'(r_found) - ((32'd1 << r_tlvl) - 32'd1);
        fsh32  = 32'(DEPTH) - 32'(r_tlvl);
        a_addr = r_base + (off32 << fsh32) + 32'd1;
        tl32   = 32'(r_tlvl);
    end

    // memory port control
    logic          we, claim_next;
    logic [NW-1:0] wa, ra;
    logic [1:0]    wd;

    always_comb begin
        we = 1'b0;
        wa = r_cur;
        wd = 2'b00;
        ra = r_cur;
        claim_next = r_claim & r_rd[1];
        case (i_cmd.op)
            bba_pkg::OP_CLEAR: begin
                we = 1'b1;
                wa = r_clr;
            end
            bba_pkg::OP_RD_SIB:   ra = sib;
            bba_pkg::OP_RD_PAR:   ra = parent;
            bba_pkg::OP_WR_FOUND: begin
                we = 1'b1;
                wd = 2'b10;
            end
            bba_pkg::OP_CLAIM_WR: begin
                we = 1'b1;
                wa = parent;
                wd = {claim_next, 1'b1};
            end
            bba_pkg::OP_F_CLR: begin
                we = 1'b1;
                wd = {1'b0, r_rd[0]};
            end
            bba_pkg::OP_F_UPWR: begin
                we = 1'b1;
                wa = parent;
                wd = {1'b0, r_rd[0]};
            end
            bba_pkg::OP_F_SPLWR: begin
                we = 1'b1;
                wa = parent;
                wd = {r_rd[1], 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_base <= 32'd0;
        end else begin
            if (i_cmd.op == bba_pkg::OP_CLEAR && r_clr != LAST_NODE) r_clr <= r_clr + NW'(1);
            if (i_heap_base_we) r_base <= i_heap_base_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bba_pkg::OP_LOAD: begin
                r_act   <= i_action;
                r_cnt   <= i_slot_count;
                r_daddr <= i_data_address;
                r_hlvl  <= i_header_level;
            end
            bba_pkg::OP_START: begin
                r_cur  <= (r_act == bba_pkg::ACT_ALLOC) ? '0 : fnode;
                r_node <= fnode;
                r_lvl  <= '0;
                r_tlvl <= d_tlvl;
            end
            bba_pkg::OP_DESCEND: begin
                r_cur <= {r_cur[NW-2:0], 1'b1};
                r_lvl <= r_lvl + LW'(1);
            end
            bba_pkg::OP_NEXT_SIB: r_cur <= r_cur + NW'(1);
            bba_pkg::OP_UP: begin
                r_cur <= parent;
                r_lvl <= r_lvl - LW'(1);
            end
            bba_pkg::OP_WR_FOUND: begin
                r_found <= r_cur;
                r_claim <= 1'b1;
            end
            bba_pkg::OP_CLAIM_WR: begin
                r_claim <= claim_next;
                r_cur   <= parent;
            end
            bba_pkg::OP_F_UPWR, bba_pkg::OP_F_SPLWR: r_cur <= parent;
            bba_pkg::OP_RESTORE: r_cur <= r_node;
            bba_pkg::OP_FIN_OK: begin
                r_status <= bba_pkg::ST_OK;
                r_addr   <= (r_act == bba_pkg::ACT_ALLOC) ? a_addr : 32'd0;
                r_blvl   <= (r_act == bba_pkg::ACT_ALLOC) ? tl32[3:0] : 4'd0;
            end
            bba_pkg::OP_FIN_ERR: begin
                r_status <= d_err;
                r_addr   <= (r_act == bba_pkg::ACT_ALLOC) ? 32'hFFFF_FFFF : 32'd0;
                r_blvl   <= 4'd0;
            end
            bba_pkg::OP_FIN_NOSPACE: begin
                r_status <= bba_pkg::ST_NOSPACE;
                r_addr   <= 32'hFFFF_FFFF;
                r_blvl   <= 4'd0;
            end
            default: ;
        endcase
    end

    assign o_stat.clear_done = (r_clr == LAST_NODE);
    assign o_stat.is_free    = (r_act != bba_pkg::ACT_ALLOC);
    assign o_stat.err        = (d_err != bba_pkg::ST_OK);
    assign o_stat.at_root    = (r_cur == '0);
    assign o_stat.cur_odd    = r_cur[0];
    assign o_stat.at_target  = (r_lvl == r_tlvl);
    assign o_stat.rd_alloc   = r_rd[1];
    assign o_stat.rd_split   = r_rd[0];

    assign o_status         = r_status;
    assign o_result_address = r_addr;
    assign o_block_level    = r_blvl;

endmodule

>>> src/buddy_block_allocator.sv
// buddy block allocator top level
//
//  channel   handshake              payload
//  request   start & !busy          i_action, i_slot_count, i_data_address, i_header_level
//  result    o_valid, one cycle     o_status, o_result_address, o_block_level
//  config    i_heap_base_we         i_heap_base_wdata
//
// one item at a time; mark memory has a write and a read port; read data is registered
// allocate: read and check each node, backtrack up or right, then claim the levels above
// free: clear the block and full parents, merge free buddies; rejected items end at decode
// after reset a clearing pass over all 2*SIZE-1 nodes (2047 by default) holds busy high
// the result strobe lasts one cycle and cannot be held off
module buddy_block_allocator #(
    parameter int ARENA_SLOTS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [15:0]        i_slot_count,
    input  logic [31:0]        i_data_address,
    input  logic signed [31:0] i_header_level,
    input  logic               i_heap_base_we,
    input  logic [31:0]        i_heap_base_wdata,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [31:0]        o_result_address,
    output logic [3:0]         o_block_level
);

    // floor of log2 of the arena
    localparam int DEPTH = $clog2(ARENA_SLOTS + 1) - 1;

    bba_pkg::t_cmd     cmd;
    bba_pkg::t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    bba_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_heap_base_we    (i_heap_base_we),
        .i_heap_base_wdata (i_heap_base_wdata),
        .i_action          (i_action),
        .i_slot_count      (i_slot_count),
        .i_data_address    (i_data_address),
        .i_header_level    (i_header_level),
        .o_status          (o_status),
        .o_result_address  (o_result_address),
        .o_block_level     (o_block_level)
    );

endmodule

>>> src/bba_checker.sv
// port level checks of the buddy block allocator and their binding
`include "assert_macros.svh"

module bba_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [2:0]  o_status
);

    `BBA_ASSERT_ALWAYS(a_clear_after_reset, i_clk, !i_rst_n |=> busy)
    `BBA_ASSERT(a_take_makes_busy, i_clk, i_rst_n, (start && !busy) |=> busy)
    `BBA_ASSERT(a_valid_while_busy, i_clk, i_rst_n, o_valid |-> busy)
    `BBA_ASSERT(a_valid_single, i_clk, i_rst_n, o_valid |=> !o_valid && !busy)
    `BBA_ASSERT(a_status_range, i_clk, i_rst_n, o_valid |-> (o_status <= bba_pkg::ST_ALIGN))

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_status (o_status)
);
